FILE: src/poqi_pkg.sv
package poqi_pkg;

    // Port widths of the payload fields.
    localparam int ID_W    = 5;
    localparam int QUEUE_W = 3;
    localparam int PRI_W   = 5;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_TASKS      = 16;
    localparam int DEF_NUM_QUEUES     = 8;
    localparam int DEF_NUM_PRIORITIES = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_CHK,
        ST_HEAD_CMP,
        ST_WALK,
        ST_LINK1,
        ST_LINK2,
        ST_DONE
    } poqi_state_t;

    // Write enables and read strobe for the link tables.
    typedef struct packed {
        logic next_we;
        logic prev_we;
        logic pri_we;
        logic rd_en;
    } poqi_link_ctl_t;

    typedef struct packed {
        logic [ID_W-1:0] new_head;
        logic [ID_W-1:0] predecessor_id;
        logic [ID_W-1:0] successor_id;
        logic            head_changed;
    } poqi_result_t;

endpackage

FILE: src/priority_ordered_queue_insert.sv
// Priority-ordered queue insert. Each input transfer inserts one task into one of
// NUM_QUEUES circular doubly linked queues, kept sorted by priority (a lower
// number is more urgent, equal priorities stay in arrival order), and returns
// one result transfer with the queue head afterwards, the task's new
// predecessor and successor, and whether the task became the head. A bad task
// ID or queue number changes nothing and returns all zeros; priorities are
// clamped to 1..NUM_PRIORITIES. The task must not already be queued. A walk
// visits at most MAX_TASKS entries of the queue. The walk is set by the link
// table, which is read at one entry per cycle. A finished result waits in an
// output register, so the next item can be accepted while it is unread; only
// while that register is still full does the sequencer hold its result and
// stay busy.
module priority_ordered_queue_insert
    import poqi_pkg::*;
#(
    parameter int MAX_TASKS      = DEF_MAX_TASKS,
    parameter int NUM_QUEUES     = DEF_NUM_QUEUES,
    parameter int NUM_PRIORITIES = DEF_NUM_PRIORITIES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [QUEUE_W-1:0] s_queue_id,
    input  logic [ID_W-1:0]    s_task_id,
    input  logic [PRI_W-1:0]   s_task_priority,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ID_W-1:0]    m_new_head,
    output logic [ID_W-1:0]    m_predecessor_id,
    output logic [ID_W-1:0]    m_successor_id,
    output logic               m_head_changed
);

    localparam int SlotW = $clog2(MAX_TASKS + 1);
    localparam int PriW  = $clog2(NUM_PRIORITIES + 1);
    localparam int QIdxW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    logic             head_rd_en;
    logic [QIdxW-1:0] head_rd_addr;
    logic             head_we;
    logic [QIdxW-1:0] head_waddr;
    logic [SlotW-1:0] head_wdata;
    logic [SlotW-1:0] head_rd_data;

    poqi_link_ctl_t   link_ctl;
    logic [SlotW-1:0] next_waddr;
    logic [SlotW-1:0] next_wdata;
    logic [SlotW-1:0] prev_waddr;
    logic [SlotW-1:0] prev_wdata;
    logic [SlotW-1:0] pri_waddr;
    logic [PriW-1:0]  pri_wdata;
    logic [SlotW-1:0] link_rd_addr;
    logic [SlotW-1:0] rd_next;
    logic [SlotW-1:0] rd_prev;
    logic [PriW-1:0]  rd_pri;

    logic             res_valid;
    logic             res_ready;
    poqi_result_t     res;

    logic             m_valid_reg, m_valid_next;
    poqi_result_t     m_res_reg;

    poqi_head_tbl #(
        .MAX_TASKS  (MAX_TASKS),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_head_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (head_rd_en),
        .rd_addr (head_rd_addr),
        .we      (head_we),
        .waddr   (head_waddr),
        .wdata   (head_wdata),
        .rd_data (head_rd_data)
    );

    poqi_link_mem #(
        .MAX_TASKS      (MAX_TASKS),
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_link_mem (
        .aclk       (aclk),
        .ctl        (link_ctl),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .pri_waddr  (pri_waddr),
        .pri_wdata  (pri_wdata),
        .rd_addr    (link_rd_addr),
        .rd_next    (rd_next),
        .rd_prev    (rd_prev),
        .rd_pri     (rd_pri)
    );

    poqi_ctrl #(
        .MAX_TASKS      (MAX_TASKS),
        .NUM_QUEUES     (NUM_QUEUES),
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_queue_id      (s_queue_id),
        .s_task_id       (s_task_id),
        .s_task_priority (s_task_priority),
        .head_rd_en      (head_rd_en),
        .head_rd_addr    (head_rd_addr),
        .head_we         (head_we),
        .head_waddr      (head_waddr),
        .head_wdata      (head_wdata),
        .head_rd_data    (head_rd_data),
        .link_ctl        (link_ctl),
        .next_waddr      (next_waddr),
        .next_wdata      (next_wdata),
        .prev_waddr      (prev_waddr),
        .prev_wdata      (prev_wdata),
        .pri_waddr       (pri_waddr),
        .pri_wdata       (pri_wdata),
        .link_rd_addr    (link_rd_addr),
        .rd_next         (rd_next),
        .rd_prev         (rd_prev),
        .rd_pri          (rd_pri),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    // The output register takes a new result whenever it is empty or being
    // drained in the same cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_new_head       = m_res_reg.new_head;
    assign m_predecessor_id = m_res_reg.predecessor_id;
    assign m_successor_id   = m_res_reg.successor_id;
    assign m_head_changed   = m_res_reg.head_changed;

    // An accepted transfer keeps the sequencer busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sequencer ready right after accepting a transfer");

    // A pending result belongs to an item in flight, never to an idle sequencer.
    a_result_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_ready)
        else $error("result offered while the sequencer is idle");

    // A result that could not be stored is still offered in the next cycle.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while the output register was full");

    // The output register fills only from a result handed over by the sequencer.
    a_output_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(res_valid))
        else $error("output transfer appeared without a result");

endmodule

FILE: src/poqi_link_mem.sv
// Task-indexed link tables: successor, predecessor and priority per task slot.
// Slot 0 is a spare slot for IDs that name no task.
module poqi_link_mem
    import poqi_pkg::*;
#(
    parameter int MAX_TASKS      = DEF_MAX_TASKS,
    parameter int NUM_PRIORITIES = DEF_NUM_PRIORITIES,
    localparam int SlotW = $clog2(MAX_TASKS + 1),
    localparam int PriW  = $clog2(NUM_PRIORITIES + 1)
) (
    input  logic             aclk,
    input  poqi_link_ctl_t   ctl,
    input  logic [SlotW-1:0] next_waddr,
    input  logic [SlotW-1:0] next_wdata,
    input  logic [SlotW-1:0] prev_waddr,
    input  logic [SlotW-1:0] prev_wdata,
    input  logic [SlotW-1:0] pri_waddr,
    input  logic [PriW-1:0]  pri_wdata,
    input  logic [SlotW-1:0] rd_addr,
    output logic [SlotW-1:0] rd_next,
    output logic [SlotW-1:0] rd_prev,
    output logic [PriW-1:0]  rd_pri
);

    localparam int Depth = MAX_TASKS + 1;

    logic [SlotW-1:0] next_mem [Depth];
    logic [SlotW-1:0] prev_mem [Depth];
    logic [PriW-1:0]  pri_mem  [Depth];

    logic [SlotW-1:0] rd_next_reg;
    logic [SlotW-1:0] rd_prev_reg;
    logic [PriW-1:0]  rd_pri_reg;

    always_ff @(posedge aclk) begin
        if (ctl.next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (ctl.prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (ctl.pri_we) begin
            pri_mem[pri_waddr] <= pri_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
            rd_pri_reg  <= pri_mem[rd_addr];
        end
    end

    assign rd_next = rd_next_reg;
    assign rd_prev = rd_prev_reg;
    assign rd_pri  = rd_pri_reg;

endmodule

FILE: src/poqi_head_tbl.sv
// Queue head table. A queue whose valid bit is clear reads as empty (zero).
module poqi_head_tbl
    import poqi_pkg::*;
#(
    parameter int MAX_TASKS  = DEF_MAX_TASKS,
    parameter int NUM_QUEUES = DEF_NUM_QUEUES,
    localparam int SlotW = $clog2(MAX_TASKS + 1),
    localparam int QIdxW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [QIdxW-1:0] rd_addr,
    input  logic             we,
    input  logic [QIdxW-1:0] waddr,
    input  logic [SlotW-1:0] wdata,
    output logic [SlotW-1:0] rd_data
);

    logic [SlotW-1:0]      head_mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] valid_reg;
    logic [SlotW-1:0]      rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            head_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? head_mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/poqi_ctrl.sv
// Insertion sequencer. One link-table read per cycle; a single priority
// comparator decides both the head comparison and each step of the walk.
module poqi_ctrl
    import poqi_pkg::*;
#(
    parameter int MAX_TASKS      = DEF_MAX_TASKS,
    parameter int NUM_QUEUES     = DEF_NUM_QUEUES,
    parameter int NUM_PRIORITIES = DEF_NUM_PRIORITIES,
    localparam int SlotW = $clog2(MAX_TASKS + 1),
    localparam int PriW  = $clog2(NUM_PRIORITIES + 1),
    localparam int QIdxW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [QUEUE_W-1:0] s_queue_id,
    input  logic [ID_W-1:0]    s_task_id,
    input  logic [PRI_W-1:0]   s_task_priority,
    output logic               head_rd_en,
    output logic [QIdxW-1:0]   head_rd_addr,
    output logic               head_we,
    output logic [QIdxW-1:0]   head_waddr,
    output logic [SlotW-1:0]   head_wdata,
    input  logic [SlotW-1:0]   head_rd_data,
    output poqi_link_ctl_t     link_ctl,
    output logic [SlotW-1:0]   next_waddr,
    output logic [SlotW-1:0]   next_wdata,
    output logic [SlotW-1:0]   prev_waddr,
    output logic [SlotW-1:0]   prev_wdata,
    output logic [SlotW-1:0]   pri_waddr,
    output logic [PriW-1:0]    pri_wdata,
    output logic [SlotW-1:0]   link_rd_addr,
    input  logic [SlotW-1:0]   rd_next,
    input  logic [SlotW-1:0]   rd_prev,
    input  logic [PriW-1:0]    rd_pri,
    output logic               res_valid,
    input  logic               res_ready,
    output poqi_result_t       res
);

    localparam int CntW = $clog2(MAX_TASKS);

    function automatic logic [SlotW-1:0] slot_of(input logic [SlotW-1:0] id);
        return (32'(id) <= MAX_TASKS) ? id : '0;
    endfunction

    poqi_state_t state_reg, state_next;

    logic [QIdxW-1:0] q_reg;
    logic [SlotW-1:0] t_reg;
    logic [PriW-1:0]  pri_reg;
    logic [SlotW-1:0] head_reg;
    logic [SlotW-1:0] cur_reg;
    logic [SlotW-1:0] pt_reg;
    logic [CntW-1:0]  cnt_reg;
    logic [SlotW-1:0] nh_reg;
    logic [SlotW-1:0] pred_reg;
    logic [SlotW-1:0] succ_reg;
    logic             chg_reg;

    logic             in_ok;
    logic [PriW-1:0]  pri_in;
    logic             pri_lt;
    logic             walk_stop;
    logic             cnt_last;
    logic             head_empty;

    assign in_ok = (32'(s_queue_id) < NUM_QUEUES) && (s_task_id != '0)
                   && (32'(s_task_id) <= MAX_TASKS);

    always_comb begin
        if (s_task_priority == '0) begin
            pri_in = PriW'(1);
        end else if (32'(s_task_priority) > NUM_PRIORITIES) begin
            pri_in = PriW'(NUM_PRIORITIES);
        end else begin
            pri_in = PriW'(s_task_priority);
        end
    end

    // Shared comparator: the new task against the entry just read.
    assign pri_lt     = pri_reg < rd_pri;
    assign walk_stop  = pri_lt || (cur_reg == head_reg);
    assign cnt_last   = cnt_reg == CntW'(MAX_TASKS - 1);
    assign head_empty = head_rd_data == '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = in_ok ? ST_HEAD_RD : ST_DONE;
                end
            end
            ST_HEAD_RD:  state_next = ST_HEAD_CHK;
            ST_HEAD_CHK: state_next = head_empty ? ST_DONE : ST_HEAD_CMP;
            ST_HEAD_CMP: state_next = pri_lt ? ST_LINK1 : ST_WALK;
            ST_WALK: begin
                if (walk_stop || cnt_last) begin
                    state_next = ST_LINK1;
                end
            end
            ST_LINK1:    state_next = ST_LINK2;
            ST_LINK2:    state_next = ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign head_rd_addr = q_reg;
    assign head_waddr   = q_reg;
    assign head_wdata   = t_reg;
    assign pri_waddr    = t_reg;
    assign pri_wdata    = pri_reg;

    always_comb begin
        s_ready      = 1'b0;
        head_rd_en   = 1'b0;
        head_we      = 1'b0;
        link_ctl     = '0;
        next_waddr   = t_reg;
        next_wdata   = t_reg;
        prev_waddr   = t_reg;
        prev_wdata   = t_reg;
        link_rd_addr = slot_of(rd_next);
        res_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_HEAD_RD: begin
                link_ctl.pri_we = 1'b1;
                head_rd_en      = 1'b1;
            end
            ST_HEAD_CHK: begin
                if (head_empty) begin
                    head_we          = 1'b1;
                    link_ctl.next_we = 1'b1;
                    link_ctl.prev_we = 1'b1;
                end else begin
                    link_ctl.rd_en = 1'b1;
                    link_rd_addr   = slot_of(head_rd_data);
                end
            end
            ST_HEAD_CMP: begin
                if (pri_lt) begin
                    head_we = 1'b1;
                end else begin
                    link_ctl.rd_en = 1'b1;
                end
            end
            ST_WALK: begin
                link_ctl.rd_en = !(walk_stop || cnt_last);
            end
            ST_LINK1: begin
                link_ctl.next_we = 1'b1;
                next_wdata       = cur_reg;
                link_ctl.prev_we = 1'b1;
                prev_wdata       = pt_reg;
            end
            ST_LINK2: begin
                link_ctl.prev_we = 1'b1;
                prev_waddr       = cur_reg;
                link_ctl.next_we = 1'b1;
                next_waddr       = slot_of(pred_reg);
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                q_reg    <= QIdxW'(s_queue_id);
                t_reg    <= SlotW'(s_task_id);
                pri_reg  <= pri_in;
                nh_reg   <= '0;
                pred_reg <= '0;
                succ_reg <= '0;
                chg_reg  <= 1'b0;
            end
            ST_HEAD_CHK: begin
                head_reg <= head_rd_data;
                cur_reg  <= slot_of(head_rd_data);
                if (head_empty) begin
                    nh_reg   <= t_reg;
                    pred_reg <= t_reg;
                    succ_reg <= t_reg;
                    chg_reg  <= 1'b1;
                end
            end
            ST_HEAD_CMP: begin
                if (pri_lt) begin
                    nh_reg  <= t_reg;
                    chg_reg <= 1'b1;
                    pt_reg  <= rd_prev;
                end else begin
                    nh_reg  <= head_reg;
                    chg_reg <= 1'b0;
                    cur_reg <= slot_of(rd_next);
                    cnt_reg <= '0;
                end
            end
            ST_WALK: begin
                if (walk_stop || cnt_last) begin
                    pt_reg <= rd_prev;
                end else begin
                    cur_reg <= slot_of(rd_next);
                    cnt_reg <= cnt_reg + CntW'(1);
                end
            end
            ST_LINK1: begin
                // Reinserting the successor itself leaves it as its own predecessor.
                pred_reg <= (cur_reg == t_reg) ? t_reg : pt_reg;
            end
            ST_LINK2: begin
                succ_reg <= (slot_of(pred_reg) == t_reg) ? t_reg : cur_reg;
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign res.new_head       = ID_W'(nh_reg);
    assign res.predecessor_id = ID_W'(pred_reg);
    assign res.successor_id   = ID_W'(succ_reg);
    assign res.head_changed   = chg_reg;

endmodule

FILE: tb/tb_priority_ordered_queue_insert.sv
`timescale 1ns / 1ps

module tb_priority_ordered_queue_insert
    import poqi_pkg::*;
();

    // Scoreboard: keeps its own copy of the queue tables, predicts the result of
    // every accepted insert and compares the results in arrival order.
    class insert_scoreboard;

        int unsigned  head_of [DEF_NUM_QUEUES];
        int unsigned  next_of [DEF_MAX_TASKS + 1];
        int unsigned  prev_of [DEF_MAX_TASKS + 1];
        int unsigned  prio_of [DEF_MAX_TASKS + 1];
        poqi_result_t awaited [$];
        int           mismatches;
        int           checked;
        int           head_moves;
        int           rejected;

        function new();
            foreach (head_of[i]) head_of[i] = 0;
            foreach (next_of[i]) begin
                next_of[i] = 0;
                prev_of[i] = 0;
                prio_of[i] = 0;
            end
            mismatches = 0;
            checked    = 0;
            head_moves = 0;
            rejected   = 0;
        endfunction

        // Slot 0 is the spare slot for IDs that name no task.
        function int unsigned slot(int unsigned id);
            return (id >= 1 && id <= DEF_MAX_TASKS) ? id : 0;
        endfunction

        function void note_insert(logic [QUEUE_W-1:0] q, logic [ID_W-1:0] tid,
                                  logic [PRI_W-1:0] prio_in);
            poqi_result_t want;
            int unsigned  prio;
            int unsigned  t;
            int unsigned  hd;
            int unsigned  cur;
            int unsigned  step;
            want = '0;
            if (q >= DEF_NUM_QUEUES || tid < 1 || tid > DEF_MAX_TASKS) begin
                rejected++;
                awaited.push_back(want);
                return;
            end
            prio = 32'(prio_in);
            if (prio < 1) prio = 1;
            if (prio > DEF_NUM_PRIORITIES) prio = DEF_NUM_PRIORITIES;
            t = 32'(tid);
            prio_of[t] = prio;
            hd = head_of[q];
            if (hd == 0) begin
                head_of[q] = t;
                next_of[t] = t;
                prev_of[t] = t;
                want.predecessor_id = ID_W'(t);
                want.successor_id   = ID_W'(t);
                want.head_changed   = 1'b1;
            end else begin
                cur = slot(hd);
                if (prio < prio_of[cur]) begin
                    head_of[q] = t;
                    want.head_changed = 1'b1;
                end else begin
                    for (step = 0; step < DEF_MAX_TASKS; step++) begin
                        cur = slot(next_of[cur]);
                        if (!(prio >= prio_of[cur] && cur != hd)) break;
                    end
                end
                // The order of these updates matters when the task is already linked.
                next_of[t]               = cur;
                prev_of[t]               = prev_of[cur];
                prev_of[cur]             = t;
                next_of[slot(prev_of[t])] = t;
                want.predecessor_id = ID_W'(prev_of[t]);
                want.successor_id   = ID_W'(next_of[t]);
            end
            want.new_head = ID_W'(head_of[q]);
            awaited.push_back(want);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40) $display("%0t: mismatch: %s", $realtime, what);
        endtask

        task check_result(poqi_result_t got);
            poqi_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result head %0d pred %0d succ %0d with nothing awaited",
                                          got.new_head, got.predecessor_id, got.successor_id));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (want.head_changed) head_moves++;
            if (got.new_head !== want.new_head)
                report_mismatch($sformatf("result %0d new_head %0d, expected %0d",
                                          checked, got.new_head, want.new_head));
            if (got.predecessor_id !== want.predecessor_id)
                report_mismatch($sformatf("result %0d predecessor_id %0d, expected %0d",
                                          checked, got.predecessor_id, want.predecessor_id));
            if (got.successor_id !== want.successor_id)
                report_mismatch($sformatf("result %0d successor_id %0d, expected %0d",
                                          checked, got.successor_id, want.successor_id));
            if (got.head_changed !== want.head_changed)
                report_mismatch($sformatf("result %0d head_changed %0b, expected %0b",
                                          checked, got.head_changed, want.head_changed));
        endtask

        task check_drained();
            if (awaited.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", awaited.size()));
        endtask
    endclass

    // Cycles with no transfer on either channel before the run is declared hung.
    // The longest quiet stretch in a correct run is the receiver hold-off below.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1180;
    localparam int QUIET_ITEMS    = 150;
    localparam int BURST_ITEMS    = 30;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [QUEUE_W-1:0] s_queue_id      = '0;
    logic [ID_W-1:0]    s_task_id       = '0;
    logic [PRI_W-1:0]   s_task_priority = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [ID_W-1:0]    m_new_head;
    logic [ID_W-1:0]    m_predecessor_id;
    logic [ID_W-1:0]    m_successor_id;
    logic               m_head_changed;

    // Flags from the stimulus process to the result sink, always set with
    // nonblocking assignments so that the sink sees them only at the next edge.
    logic               quiet_mode      = 1'b0;
    logic               hold_request    = 1'b0;

    insert_scoreboard   sb;
    int                 sent_count      = 0;
    int                 idle_cycles     = 0;

    priority_ordered_queue_insert u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_queue_id       (s_queue_id),
        .s_task_id        (s_task_id),
        .s_task_priority  (s_task_priority),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_new_head       (m_new_head),
        .m_predecessor_id (m_predecessor_id),
        .m_successor_id   (m_successor_id),
        .m_head_changed   (m_head_changed)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Offers one insert request and returns at the edge where it is taken.
    // Valid is left high, so back-to-back calls keep the channel busy without
    // a bubble; only sender_gap and wait_drained lower it.
    task automatic send_insert(input logic [QUEUE_W-1:0] q, input logic [ID_W-1:0] tid,
                               input logic [PRI_W-1:0] prio);
        s_valid         <= 1'b1;
        s_queue_id      <= q;
        s_task_id       <= tid;
        s_task_priority <= prio;
        do @(posedge aclk); while (!s_ready);
        sb.note_insert(q, tid, prio);
        sent_count++;
    endtask

    // A random burst of idle cycles on the input side, skipped in the quiet
    // closing part of the run.
    task automatic sender_gap();
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic send_directed(input logic [QUEUE_W-1:0] q, input logic [ID_W-1:0] tid,
                                 input logic [PRI_W-1:0] prio);
        send_insert(q, tid, prio);
        sender_gap();
    endtask

    // Random request. Once every task has been inserted (there is no removal),
    // most requests re-insert a queued task. Task IDs and priorities outside
    // the legal range are mixed in so that every input bit toggles.
    task automatic send_random();
        logic [QUEUE_W-1:0] q;
        logic [ID_W-1:0]    tid;
        logic [PRI_W-1:0]   prio;
        q = QUEUE_W'($urandom_range(0, DEF_NUM_QUEUES - 1));
        if ($urandom_range(0, 9) == 0)
            tid = ($urandom_range(0, 1) == 0) ? '0
                                              : ID_W'($urandom_range(DEF_MAX_TASKS + 1, 31));
        else
            tid = ID_W'($urandom_range(1, DEF_MAX_TASKS));
        if ($urandom_range(0, 4) == 0)
            prio = PRI_W'($urandom_range(0, 31));
        else
            prio = PRI_W'($urandom_range(1, DEF_NUM_PRIORITIES));
        send_insert(q, tid, prio);
    endtask

    // Waits, with valid low, until every awaited result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.awaited.size() != 0);
    endtask

    // Result sink. It checks each transfer on the result channel and decides
    // m_ready for the next cycle: random stall bursts, one long hold-off on
    // request, and no new stall bursts once the quiet part has begun.
    initial begin : result_sink
        int           stall_left;
        int           hold_left;
        bit           hold_taken;
        logic         ready_next;
        poqi_result_t got;
        stall_left = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.new_head       = m_new_head;
                got.predecessor_id = m_predecessor_id;
                got.successor_id   = m_successor_id;
                got.head_changed   = m_head_changed;
                sb.check_result(got);
            end
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_ready <= ready_next;
        end
    end

    // Watchdog: a run that stops moving on both channels is hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("[priority_ordered_queue_insert] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Queue 0 is built up step by step: an empty queue, an
        // equal priority that must go behind the head, takeovers of the head
        // (one by a clamped priority of zero), a clamped oversized priority at
        // the tail and a long walk that wraps around to the head.
        send_directed(3'd0, 5'd0,  5'd5);
        send_directed(3'd0, 5'd1,  5'd8);
        send_directed(3'd0, 5'd2,  5'd8);
        send_directed(3'd0, 5'd3,  5'd3);
        send_directed(3'd0, 5'd4,  5'd0);
        send_directed(3'd0, 5'd5,  5'd31);
        send_directed(3'd0, 5'd6,  5'd8);
        send_directed(3'd0, 5'd7,  5'd16);
        // Task IDs outside 1..16 change nothing and return zeros.
        send_directed(3'd3, 5'd31, 5'd4);
        send_directed(3'd5, 5'd17, 5'd9);
        // Queue 7: a tie with the head does not take it over.
        send_directed(3'd7, 5'd8,  5'd16);
        send_directed(3'd7, 5'd9,  5'd1);
        send_directed(3'd7, 5'd10, 5'd1);
        send_directed(3'd0, 5'd11, 5'd16);
        send_directed(3'd1, 5'd12, 5'd17);
        send_directed(3'd2, 5'd13, 5'd2);
        send_directed(3'd2, 5'd14, 5'd30);
        send_directed(3'd2, 5'd15, 5'd15);
        send_directed(3'd6, 5'd16, 5'd12);
        // Re-inserting a task that is already queued is carried out anyway.
        send_directed(3'd0, 5'd1,  5'd4);
        send_directed(3'd7, 5'd0,  5'd0);
        send_directed(3'd7, 5'd31, 5'd31);

        // The sender holds back until the block has delivered everything.
        wait_drained();

        // The receiver holds off for a long stretch while requests keep coming
        // back to back, so the output register fills and s_ready drops.
        hold_request <= 1'b1;
        repeat (BURST_ITEMS) send_random();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet_mode <= 1'b1;
            send_random();
            sender_gap();
        end

        // Let the last results drain, then idle before the final check.
        wait_drained();
        repeat (50) @(posedge aclk);
        sb.check_drained();

        $display("Sent %0d insert requests, %0d with a task ID out of range; checked %0d results.",
                 sent_count, sb.rejected, sb.checked);
        $display("%0d inserts took the head; empty queues, ties, clamped priorities, reinsertion %s",
                 sb.head_moves, "and a long receiver hold-off were exercised.");
        if (sb.mismatches == 0) begin
            $display("[priority_ordered_queue_insert] OK");
        end else begin
            $display("[priority_ordered_queue_insert] ERROR");
        end
        $finish;
    end

endmodule

FILE: priority_ordered_queue_insert.f
src/poqi_pkg.sv
src/poqi_link_mem.sv
src/poqi_head_tbl.sv
src/poqi_ctrl.sv
src/priority_ordered_queue_insert.sv
tb/tb_priority_ordered_queue_insert.sv
